// ----- rtl/ppm_pkg.sv -----
package ppm_pkg;

	localparam int COORD_BITS     = 16;
	localparam int COEF_FRAC_BITS = 32;
	localparam int COEF_W         = 48;
	localparam int IN_W           = 16;
	localparam int OUT_W          = 32;
	localparam int OUT_FRAC       = 16;
	localparam int REG_IDX_W      = 3;

	// product, dot-product sum and magnitude widths
	localparam int PROD_W = COEF_W + COORD_BITS;
	localparam int SUM_W  = PROD_W + 2;
	localparam int MAG_W  = SUM_W;
	// remainder wide enough for the divisor shifted by the top quotient bit
	localparam int REM_W  = MAG_W + OUT_W + 1;
	localparam int DIV_STAGES = OUT_W;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [1:0]               status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_DEN_ZERO = 2'd1;
	localparam status_t ST_SAT      = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_GAIN_XX  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_XY  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_YX  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN_YY  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_PERSP_X  = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_PERSP_Y  = 3'd7;

	localparam coef_t COEF_ONE = coef_t'(64'd1 << COEF_FRAC_BITS);

endpackage

// ----- rtl/perspective_point_map_unit.sv -----
// Projective point map: (x,y) -> ((a*x+b*y+c)/(g*x+h*y+1), (d*x+e*y+f)/(g*x+h*y+1)).
// Coefficients are signed Q16.32 registers written through cfg_we / cfg_idx / cfg_wdata;
// write them only while no item is in flight.
// An item (src_x, src_y) is taken at a clock edge with start high; busy is always low,
// so a new item may be given in every cycle.
// Each result is shown on dst_x, dst_y and map_status for one cycle with done high.
// Throughput is one item per clock. The pipeline has five stages of products, sums,
// magnitudes and overflow checks, then one stage per quotient bit (32), then the
// output register.
// Results are Q16.16, rounded to nearest with ties away from zero, and saturated;
// map_status is 0 for ok, 1 for a zero denominator (outputs zero), 2 when saturated.
// Reset loads the identity map and empties the pipeline; the receiver cannot stall,
// so results leave in order, one per accepted item.
module perspective_point_map_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [ppm_pkg::IN_W-1:0]   src_x,
	input  logic signed [ppm_pkg::IN_W-1:0]   src_y,
	input  logic                              cfg_we,
	input  logic [ppm_pkg::REG_IDX_W-1:0]     cfg_idx,
	input  logic [ppm_pkg::COEF_W-1:0]        cfg_wdata,
	output logic                              done,
	output logic signed [ppm_pkg::OUT_W-1:0]  dst_x,
	output logic signed [ppm_pkg::OUT_W-1:0]  dst_y,
	output logic [1:0]                        map_status
);
	import ppm_pkg::*;

	coef_t a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic                      vld_s1;
	logic signed [PROD_W-1:0]  pa_s1, pb_s1, pd_s1, pe_s1, pg_s1, ph_s1;
	coef_t                     c_s1, f_s1;

	logic                      vld_s2;
	logic signed [SUM_W-1:0]   nx_s2, ny_s2, dn_s2;

	logic                      vld_s3, zero_s3, negx_s3, negy_s3, negd_s3;
	logic [MAG_W-1:0]          nxm_s3, nym_s3, dm_s3;

	logic                      vld_s4, zero_s4, negx_s4, negy_s4;
	logic [REM_W-1:0]          nx_s4, ny_s4, thx_s4, thy_s4, d_s4;

	logic                      vld_s5, zero_s5, negx_s5, negy_s5, satx_s5, saty_s5;

	logic                      vld_sd  [DIV_STAGES+1];
	logic                      zero_sd [DIV_STAGES+1];
	logic                      negx_sd [DIV_STAGES+1];
	logic                      negy_sd [DIV_STAGES+1];
	logic                      sat_sd  [DIV_STAGES+1];
	logic                      satx_sd [DIV_STAGES+1];
	logic                      saty_sd [DIV_STAGES+1];
	logic [REM_W-1:0]          rx_sd   [DIV_STAGES+1];
	logic [REM_W-1:0]          ry_sd   [DIV_STAGES+1];
	logic [REM_W-1:0]          dv_sd   [DIV_STAGES+1];
	logic [OUT_W-1:0]          qx_sd   [DIV_STAGES+1];
	logic [OUT_W-1:0]          qy_sd   [DIV_STAGES+1];

	logic signed [COORD_BITS-1:0] x_c, y_c;
	logic signed [SUM_W-1:0]      nx_c, ny_c, dn_c;
	logic [MAG_W-1:0]             dm_c;
	logic [OUT_W-1:0]             limx_c, limy_c, magx_c, magy_c;

	assign busy = 1'b0;

	// hold the coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= COEF_ONE;
			b_q <= '0;
			c_q <= '0;
			d_q <= '0;
			e_q <= COEF_ONE;
			f_q <= '0;
			g_q <= '0;
			h_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAIN_XX:  a_q <= cfg_wdata;
				REG_GAIN_XY:  b_q <= cfg_wdata;
				REG_OFFSET_X: c_q <= cfg_wdata;
				REG_GAIN_YX:  d_q <= cfg_wdata;
				REG_GAIN_YY:  e_q <= cfg_wdata;
				REG_OFFSET_Y: f_q <= cfg_wdata;
				REG_PERSP_X:  g_q <= cfg_wdata;
				REG_PERSP_Y:  h_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign x_c = src_x[COORD_BITS-1:0];
	assign y_c = src_y[COORD_BITS-1:0];

	// stage 1: coefficient products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		pa_s1 <= PROD_W'(a_q * x_c);
		pb_s1 <= PROD_W'(b_q * y_c);
		pd_s1 <= PROD_W'(d_q * x_c);
		pe_s1 <= PROD_W'(e_q * y_c);
		pg_s1 <= PROD_W'(g_q * x_c);
		ph_s1 <= PROD_W'(h_q * y_c);
		c_s1  <= c_q;
		f_s1  <= f_q;
	end

	// stage 2: dot products
	assign nx_c = SUM_W'(pa_s1) + SUM_W'(pb_s1) + SUM_W'(c_s1);
	assign ny_c = SUM_W'(pd_s1) + SUM_W'(pe_s1) + SUM_W'(f_s1);
	assign dn_c = SUM_W'(pg_s1) + SUM_W'(ph_s1) + SUM_W'(COEF_ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		nx_s2 <= nx_c;
		ny_s2 <= ny_c;
		dn_s2 <= dn_c;
	end

	// stage 3: signs and magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		zero_s3 <= (dn_s2 == '0);
		negx_s3 <= nx_s2[SUM_W-1];
		negy_s3 <= ny_s2[SUM_W-1];
		negd_s3 <= dn_s2[SUM_W-1];
		nxm_s3  <= nx_s2[SUM_W-1] ? MAG_W'(-nx_s2) : MAG_W'(nx_s2);
		nym_s3  <= ny_s2[SUM_W-1] ? MAG_W'(-ny_s2) : MAG_W'(ny_s2);
		dm_s3   <= dn_s2[SUM_W-1] ? MAG_W'(-dn_s2) : MAG_W'(dn_s2);
	end

	// stage 4: scale and round the numerators, form the saturation thresholds
	assign dm_c = dm_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		zero_s4 <= zero_s3;
		negx_s4 <= negx_s3 ^ negd_s3;
		negy_s4 <= negy_s3 ^ negd_s3;
		nx_s4   <= (REM_W'(nxm_s3) << OUT_FRAC) + REM_W'(dm_c >> 1);
		ny_s4   <= (REM_W'(nym_s3) << OUT_FRAC) + REM_W'(dm_c >> 1);
		// the limit is 2^31-1 for a positive result, 2^31 for a negative one
		thx_s4  <= (REM_W'(dm_c) << (OUT_W-1))
			+ ((negx_s3 ^ negd_s3) ? REM_W'(dm_c) : '0);
		thy_s4  <= (REM_W'(dm_c) << (OUT_W-1))
			+ ((negy_s3 ^ negd_s3) ? REM_W'(dm_c) : '0);
		d_s4    <= REM_W'(dm_c);
	end

	// stage 5: saturation checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		zero_s5 <= zero_s4;
		negx_s5 <= negx_s4;
		negy_s5 <= negy_s4;
		satx_s5 <= (nx_s4 >= thx_s4);
		saty_s5 <= (ny_s4 >= thy_s4);
	end

	logic [REM_W-1:0] nxd_s5, nyd_s5, dd_s5;
	always_ff @(posedge clk) begin
		nxd_s5 <= nx_s4;
		nyd_s5 <= ny_s4;
		dd_s5  <= d_s4;
	end

	// quotient pipeline entry
	always_comb begin
		vld_sd[0]  = vld_s5;
		zero_sd[0] = zero_s5;
		negx_sd[0] = negx_s5;
		negy_sd[0] = negy_s5;
		satx_sd[0] = satx_s5;
		saty_sd[0] = saty_s5;
		sat_sd[0]  = satx_s5 | saty_s5;
		rx_sd[0]   = nxd_s5;
		ry_sd[0]   = nyd_s5;
		dv_sd[0]   = dd_s5;
		qx_sd[0]   = '0;
		qy_sd[0]   = '0;
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int SH = DIV_STAGES - 1 - k;
		logic [REM_W-1:0] dsx;
		logic             gex, gey;

		assign dsx = dv_sd[k] << SH;
		assign gex = (rx_sd[k] >= dsx);
		assign gey = (ry_sd[k] >= dsx);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[k+1] <= 1'b0;
			else vld_sd[k+1] <= vld_sd[k];
		end
		always_ff @(posedge clk) begin
			zero_sd[k+1] <= zero_sd[k];
			negx_sd[k+1] <= negx_sd[k];
			negy_sd[k+1] <= negy_sd[k];
			satx_sd[k+1] <= satx_sd[k];
			saty_sd[k+1] <= saty_sd[k];
			sat_sd[k+1]  <= sat_sd[k];
			dv_sd[k+1]   <= dv_sd[k];
			rx_sd[k+1]   <= gex ? rx_sd[k] - dsx : rx_sd[k];
			ry_sd[k+1]   <= gey ? ry_sd[k] - dsx : ry_sd[k];
			qx_sd[k+1]   <= qx_sd[k] | (gex ? OUT_W'(1) << SH : '0);
			qy_sd[k+1]   <= qy_sd[k] | (gey ? OUT_W'(1) << SH : '0);
		end
	end

	// clamp, apply sign
	assign limx_c = negx_sd[DIV_STAGES] ? OUT_W'(1) << (OUT_W-1) : ~(OUT_W'(1) << (OUT_W-1));
	assign limy_c = negy_sd[DIV_STAGES] ? OUT_W'(1) << (OUT_W-1) : ~(OUT_W'(1) << (OUT_W-1));
	assign magx_c = satx_sd[DIV_STAGES] ? limx_c : qx_sd[DIV_STAGES];
	assign magy_c = saty_sd[DIV_STAGES] ? limy_c : qy_sd[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_sd[DIV_STAGES];
	end
	always_ff @(posedge clk) begin
		if (zero_sd[DIV_STAGES]) begin
			dst_x      <= '0;
			dst_y      <= '0;
			map_status <= ST_DEN_ZERO;
		end else begin
			dst_x      <= negx_sd[DIV_STAGES] ? -magx_c : magx_c;
			dst_y      <= negy_sd[DIV_STAGES] ? -magy_c : magy_c;
			map_status <= sat_sd[DIV_STAGES] ? ST_SAT : ST_OK;
		end
	end

endmodule
